[hw/rtl/aeskinv_pkg.sv]
// Shared types, constants and lookup functions for the AES-128 round key inverter.
package aeskinv_pkg;

  localparam int unsigned NumRounds = 10;
  localparam int unsigned RoundW = 4;
  localparam logic [RoundW-1:0] MaxRound = 4'd10;

  typedef struct packed {
    logic [RoundW-1:0] rounds;
    logic [127:0]      key;
  } stage_data_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  localparam logic [7:0] RCON [11] = '{
    8'h00, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
  };

  function automatic logic [31:0] rot_sub(input logic [31:0] x);
    logic [31:0] r;
    r = {x[23:0], x[31:24]};
    return {SBOX[r[31:24]], SBOX[r[23:16]], SBOX[r[15:8]], SBOX[r[7:0]]};
  endfunction

  function automatic logic [7:0] rcon(input logic [RoundW-1:0] k);
    logic [7:0] c;
    c = 8'h00;
    if (k <= MaxRound) begin
      c = RCON[k];
    end
    return c;
  endfunction

endpackage

[hw/rtl/aeskinv_stage.sv]
// One pipeline stage that undoes at most one round of the AES-128 key schedule.
module aeskinv_stage
  import aeskinv_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [RoundW-1:0] round_num,
  input  logic              in_valid,
  input  stage_data_t       in_data,
  output logic              out_valid,
  output stage_data_t       out_data
);

  logic [31:0] w0, w1, w2, w3;
  logic [31:0] p0, p1, p2, p3;
  stage_data_t data_next;

  always_comb begin
    w0 = in_data.key[127:96];
    w1 = in_data.key[95:64];
    w2 = in_data.key[63:32];
    w3 = in_data.key[31:0];
    p3 = w3 ^ w2;
    p2 = w2 ^ w1;
    p1 = w1 ^ w0;
    p0 = w0 ^ rot_sub(p3) ^ {rcon(round_num), 24'h000000};
    data_next.rounds = in_data.rounds;
    data_next.key = in_data.key;
    if (in_data.rounds >= round_num) begin
      data_next.key = {p0, p1, p2, p3};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_data <= data_next;
  end

endmodule

[hw/rtl/aes128_round_key_inverter.sv]
// Top level of the AES-128 round key inverter: config register and ten-stage pipeline.
//
// Usage: program the round number of the supplied round key through cfg_write and
// cfg_data (values above ten act as ten). Present a round key on round_key_hi and
// round_key_lo with start high; the transfer happens at any clock edge where start
// is high and busy is low. Busy is always low, so a new key may enter every cycle.
// The recovered cipher key appears on cipher_key_hi and cipher_key_lo for exactly
// one cycle, marked by done, after it has passed every pipeline stage register.
// Throughput is one key per cycle: each of the ten pipeline stages undoes at most
// one round of the key schedule with one S-box word lookup.
// Stages past the programmed round pass the key through untouched.
// Reset clears every stage valid bit, so no stray done follows reset, and sets the
// round number to ten. The receiver cannot stall; results must be taken on done.
// The round number is sampled at entry and travels with each key through the stages.
module aes128_round_key_inverter
  import aeskinv_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [3:0]  cfg_data,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] round_key_hi,
  input  logic [63:0] round_key_lo,
  output logic        done,
  output logic [63:0] cipher_key_hi,
  output logic [63:0] cipher_key_lo
);

  logic [RoundW-1:0] round_index;
  logic              stage_valid [NumRounds+1];
  stage_data_t       stage_data [NumRounds+1];

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      round_index <= MaxRound;
    end else if (cfg_write) begin
      round_index <= (cfg_data > MaxRound) ? MaxRound : cfg_data;
    end
  end

  assign stage_valid[0] = start && !busy;
  assign stage_data[0].rounds = round_index;
  assign stage_data[0].key = {round_key_hi, round_key_lo};

  for (genvar s = 0; s < NumRounds; s++) begin : g_stage
    aeskinv_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .round_num (RoundW'(NumRounds - s)),
      .in_valid  (stage_valid[s]),
      .in_data   (stage_data[s]),
      .out_valid (stage_valid[s+1]),
      .out_data  (stage_data[s+1])
    );
  end

  assign done = stage_valid[NumRounds];
  assign cipher_key_hi = stage_data[NumRounds].key[127:64];
  assign cipher_key_lo = stage_data[NumRounds].key[63:0];

`ifndef SYNTHESIS
  a_done_follows_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, NumRounds))
    else $error("done without a transfer ten cycles earlier");

  a_round_saturated: assert property (@(posedge clk) disable iff (rst)
    round_index <= MaxRound)
    else $error("round number register above ten");

  a_first_stage_tracks_start: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) |-> (stage_valid[1] == $past(start)))
    else $error("first stage valid does not follow start");

  a_last_rounds_saturated: assert property (@(posedge clk) disable iff (rst)
    done |-> (stage_data[NumRounds].rounds <= MaxRound))
    else $error("round number carried to output above ten");
`endif

endmodule
